/* rtl/core/qtm_pkg.sv */
// Shared widths, constants and arithmetic helpers for the quaternion-to-matrix pipeline.
package qtm_pkg;

	localparam int QUAT_W  = 16;
	localparam int SCALE_W = 16;
	localparam int TRANS_W = 32;
	localparam int ENTRY_W = 32;

	// 2*a*b of two Q1.15 values, exact in Q.30
	localparam int DPROD_W = 2 * QUAT_W + 1;
	// sums and differences of two doubled products, or one minus such a sum
	localparam int TERM_W = DPROD_W + 1;
	// term times Q8.8 scale, exact in Q.38
	localparam int PROD_W = TERM_W + SCALE_W;
	// Q.38 to Q16.16
	localparam int ROUND_SHIFT = 22;
	localparam int RES_W = PROD_W - ROUND_SHIFT;

	localparam logic signed [TERM_W-1:0] ONE_Q30    = TERM_W'(64'sd1 <<< 30);
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd1 <<< (ROUND_SHIFT - 1));
	localparam logic signed [63:0]       ENTRY_MAX  = 64'sd2147483647;
	localparam logic signed [63:0]       ENTRY_MIN  = -64'sd2147483648;

	typedef logic signed [DPROD_W-1:0] dprod_t;
	typedef logic signed [TERM_W-1:0]  term_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [ENTRY_W-1:0] entry_t;

	// Form 2*a*b exactly
	function automatic dprod_t dbl_prod(input logic signed [QUAT_W-1:0] a,
			input logic signed [QUAT_W-1:0] b);
		logic signed [2*QUAT_W-1:0] p;
		p = a * b;
		return $signed({p, 1'b0});
	endfunction

	// Round to nearest with ties toward plus infinity, then clamp to 32 bits
	function automatic entry_t round_sat(input prod_t p);
		prod_t                   t;
		logic signed [RES_W-1:0] r;
		logic signed [63:0]      r64;
		t   = p + ROUND_HALF;
		r   = t[PROD_W-1:ROUND_SHIFT];
		r64 = 64'(r);
		if (r64 > ENTRY_MAX) begin
			return ENTRY_W'(ENTRY_MAX);
		end else if (r64 < ENTRY_MIN) begin
			return ENTRY_W'(ENTRY_MIN);
		end
		return ENTRY_W'(r64);
	endfunction

endpackage

/* rtl/core/quaternion_transform_to_matrix.sv */
// Top level: quaternion, scale and translation to the upper 3x4 part of an affine matrix.
//
// A word is taken in every cycle in which start is high; busy is never raised. Each word
// comes out at the end of the pipeline with done high for a single cycle, and words
// leave in the order they came. The pipeline has four register stages: doubled
// quaternion products, sums into rotation terms, multiply by the row
// scale, and rounding to Q16.16 with saturation. The receiver must take every result in
// its cycle. No normalization is applied to the quaternion; translation passes through
// unchanged.
module quaternion_transform_to_matrix
	import qtm_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [QUAT_W-1:0]  rot_x,
	input  logic signed [QUAT_W-1:0]  rot_y,
	input  logic signed [QUAT_W-1:0]  rot_z,
	input  logic signed [QUAT_W-1:0]  rot_w,
	input  logic signed [TRANS_W-1:0] trans_x,
	input  logic signed [TRANS_W-1:0] trans_y,
	input  logic signed [TRANS_W-1:0] trans_z,
	input  logic signed [SCALE_W-1:0] scale_x,
	input  logic signed [SCALE_W-1:0] scale_y,
	input  logic signed [SCALE_W-1:0] scale_z,
	output logic                      done,
	output entry_t                    m11,
	output entry_t                    m12,
	output entry_t                    m13,
	output entry_t                    m21,
	output entry_t                    m22,
	output entry_t                    m23,
	output entry_t                    m31,
	output entry_t                    m32,
	output entry_t                    m33,
	output logic signed [TRANS_W-1:0] out_tx,
	output logic signed [TRANS_W-1:0] out_ty,
	output logic signed [TRANS_W-1:0] out_tz
);

	typedef struct packed {
		logic signed [TRANS_W-1:0] x;
		logic signed [TRANS_W-1:0] y;
		logic signed [TRANS_W-1:0] z;
	} trans_t;

	typedef struct packed {
		logic signed [SCALE_W-1:0] x;
		logic signed [SCALE_W-1:0] y;
		logic signed [SCALE_W-1:0] z;
	} scale_t;

	logic   accept;
	logic   valid_s1, valid_s2, valid_s3, valid_s4;
	trans_t trans_s1, trans_s2, trans_s3, trans_s4;
	scale_t scale_s1, scale_s2;

	dprod_t xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	term_t  t11_s2, t12_s2, t13_s2, t21_s2, t22_s2, t23_s2, t31_s2, t32_s2, t33_s2;

	// The pipeline never stalls
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Advance the valid bits with the words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Stage 1: form the nine doubled products
	always_ff @(posedge clk) begin
		xx_s1    <= dbl_prod(rot_x, rot_x);
		yy_s1    <= dbl_prod(rot_y, rot_y);
		zz_s1    <= dbl_prod(rot_z, rot_z);
		xy_s1    <= dbl_prod(rot_x, rot_y);
		xz_s1    <= dbl_prod(rot_x, rot_z);
		yz_s1    <= dbl_prod(rot_y, rot_z);
		wx_s1    <= dbl_prod(rot_w, rot_x);
		wy_s1    <= dbl_prod(rot_w, rot_y);
		wz_s1    <= dbl_prod(rot_w, rot_z);
		scale_s1 <= '{x: scale_x, y: scale_y, z: scale_z};
		trans_s1 <= '{x: trans_x, y: trans_y, z: trans_z};
	end

	// Stage 2: combine products into the rotation terms
	always_ff @(posedge clk) begin
		t11_s2   <= ONE_Q30 - (TERM_W'(yy_s1) + TERM_W'(zz_s1));
		t12_s2   <= TERM_W'(xy_s1) + TERM_W'(wz_s1);
		t13_s2   <= TERM_W'(xz_s1) - TERM_W'(wy_s1);
		t21_s2   <= TERM_W'(xy_s1) - TERM_W'(wz_s1);
		t22_s2   <= ONE_Q30 - (TERM_W'(xx_s1) + TERM_W'(zz_s1));
		t23_s2   <= TERM_W'(yz_s1) + TERM_W'(wx_s1);
		t31_s2   <= TERM_W'(xz_s1) + TERM_W'(wy_s1);
		t32_s2   <= TERM_W'(yz_s1) - TERM_W'(wx_s1);
		t33_s2   <= ONE_Q30 - (TERM_W'(xx_s1) + TERM_W'(yy_s1));
		scale_s2 <= scale_s1;
		trans_s2 <= trans_s1;
	end

	// Stages 3 and 4: scale each term by its row and round
	qtm_scale_round u_e11 (.clk(clk), .term(t11_s2), .scale(scale_s2.x), .entry(m11));
	qtm_scale_round u_e12 (.clk(clk), .term(t12_s2), .scale(scale_s2.x), .entry(m12));
	qtm_scale_round u_e13 (.clk(clk), .term(t13_s2), .scale(scale_s2.x), .entry(m13));
	qtm_scale_round u_e21 (.clk(clk), .term(t21_s2), .scale(scale_s2.y), .entry(m21));
	qtm_scale_round u_e22 (.clk(clk), .term(t22_s2), .scale(scale_s2.y), .entry(m22));
	qtm_scale_round u_e23 (.clk(clk), .term(t23_s2), .scale(scale_s2.y), .entry(m23));
	qtm_scale_round u_e31 (.clk(clk), .term(t31_s2), .scale(scale_s2.z), .entry(m31));
	qtm_scale_round u_e32 (.clk(clk), .term(t32_s2), .scale(scale_s2.z), .entry(m32));
	qtm_scale_round u_e33 (.clk(clk), .term(t33_s2), .scale(scale_s2.z), .entry(m33));

	// Delay the translation to match the entries
	always_ff @(posedge clk) begin
		trans_s3 <= trans_s2;
		trans_s4 <= trans_s3;
	end

	assign done   = valid_s4;
	assign out_tx = trans_s4.x;
	assign out_ty = trans_s4.y;
	assign out_tz = trans_s4.z;

endmodule

/* rtl/core/qtm_scale_round.sv */
// One matrix entry: term times row scale, then round to Q16.16 and saturate.
module qtm_scale_round
	import qtm_pkg::*;
(
	input  logic                      clk,
	input  term_t                     term,
	input  logic signed [SCALE_W-1:0] scale,
	output entry_t                    entry
);

	prod_t  prod_s3;
	entry_t entry_s4;

	// Multiply the exact term by the scale
	always_ff @(posedge clk) begin
		prod_s3 <= PROD_W'(term) * PROD_W'(scale);
	end

	// Round and clamp the product
	always_ff @(posedge clk) begin
		entry_s4 <= round_sat(prod_s3);
	end

	assign entry = entry_s4;

endmodule

/* rtl/core/qtm_checker.sv */
// Port-level checks on the quaternion-to-matrix block, bound to its top level.
module qtm_checker
	import qtm_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic signed [QUAT_W-1:0]  rot_x,
	input logic signed [QUAT_W-1:0]  rot_y,
	input logic signed [QUAT_W-1:0]  rot_z,
	input logic signed [TRANS_W-1:0] trans_x,
	input logic signed [TRANS_W-1:0] trans_y,
	input logic signed [TRANS_W-1:0] trans_z,
	input logic signed [SCALE_W-1:0] scale_x,
	input logic                      done,
	input entry_t                    m11,
	input entry_t                    m12,
	input logic signed [TRANS_W-1:0] out_tx,
	input logic signed [TRANS_W-1:0] out_ty,
	input logic signed [TRANS_W-1:0] out_tz
);

	// Every word taken is followed by its done strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("accepted word did not come out after four cycles");

	// No result without a matching word taken
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result strobe without a matching accepted word");

	// Translation passes through with its word
	a_trans: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_tx == $past(trans_x, 4) && out_ty == $past(trans_y, 4)
			&& out_tz == $past(trans_z, 4)))
		else $error("translation does not match its word");

	// A pure w quaternion gives the row scale at m11 and zero at m12
	a_identity_row: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && rot_x == '0 && rot_y == '0 && rot_z == '0) |-> ##4
		(m11 == $signed({{8{$past(scale_x[SCALE_W-1], 4)}}, $past(scale_x, 4), 8'h00})
			&& m12 == '0))
		else $error("first row wrong for a rotation-free quaternion");

endmodule

bind quaternion_transform_to_matrix qtm_checker u_qtm_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
	.trans_x(trans_x), .trans_y(trans_y), .trans_z(trans_z),
	.scale_x(scale_x), .done(done), .m11(m11), .m12(m12),
	.out_tx(out_tx), .out_ty(out_ty), .out_tz(out_tz)
);

/* dv/tb_top.sv */
// Self-checking bench for the quaternion-plus-scale to affine matrix pipeline.
`timescale 1ns / 1ps

module tb_top;
	import qtm_pkg::*;

	typedef struct packed {
		logic signed [QUAT_W-1:0]  rx;
		logic signed [QUAT_W-1:0]  ry;
		logic signed [QUAT_W-1:0]  rz;
		logic signed [QUAT_W-1:0]  rw;
		logic signed [TRANS_W-1:0] tx;
		logic signed [TRANS_W-1:0] ty;
		logic signed [TRANS_W-1:0] tz;
		logic signed [SCALE_W-1:0] sx;
		logic signed [SCALE_W-1:0] sy;
		logic signed [SCALE_W-1:0] sz;
	} xform_t;

	typedef struct packed {
		entry_t                    m11, m12, m13;
		entry_t                    m21, m22, m23;
		entry_t                    m31, m32, m33;
		logic signed [TRANS_W-1:0] tx, ty, tz;
	} matrix_t;

	localparam int     N_RANDOM    = 1500;
	localparam int     BURST_LO    = 400;
	localparam int     BURST_HI    = 700;
	localparam int     DRAIN_MID   = 1000;
	localparam int     IDLE_PCT    = 29;
	localparam longint ONE_Q30_L   = 64'sd1 <<< 30;
	localparam longint HALF_LSB    = 64'sd1 <<< 21;
	localparam longint SAT_MAX     = 64'sd2147483647;
	localparam longint SAT_MIN     = -64'sd2147483648;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	logic busy;
	logic done;
	xform_t cur  = '0;

	entry_t m11, m12, m13, m21, m22, m23, m31, m32, m33;
	logic signed [TRANS_W-1:0] out_tx, out_ty, out_tz;

	xform_t  pending_xforms[$];
	matrix_t expected_matrices[$];
	int      n_total    = 0;
	int      n_directed = 0;
	int      n_accepted = 0;
	int      n_checked  = 0;
	int      n_errors   = 0;

	quaternion_transform_to_matrix dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.rot_x   (cur.rx),
		.rot_y   (cur.ry),
		.rot_z   (cur.rz),
		.rot_w   (cur.rw),
		.trans_x (cur.tx),
		.trans_y (cur.ty),
		.trans_z (cur.tz),
		.scale_x (cur.sx),
		.scale_y (cur.sy),
		.scale_z (cur.sz),
		.done    (done),
		.m11     (m11),
		.m12     (m12),
		.m13     (m13),
		.m21     (m21),
		.m22     (m22),
		.m23     (m23),
		.m31     (m31),
		.m32     (m32),
		.m33     (m33),
		.out_tx  (out_tx),
		.out_ty  (out_ty),
		.out_tz  (out_tz)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Q.30 term times Q8.8 scale, round half up to Q16.16, clamp to 32 bits
	function automatic entry_t scaled_entry(input longint term, input longint scale);
		longint p;
		longint r;
		p = term * scale + HALF_LSB;
		r = p >>> 22;
		if (r > SAT_MAX) begin
			r = SAT_MAX;
		end else if (r < SAT_MIN) begin
			r = SAT_MIN;
		end
		return entry_t'(r);
	endfunction

	// Rotation-and-scale entries plus translation for one transform
	function automatic matrix_t predict_matrix(input xform_t t);
		longint qx, qy, qz, qw;
		longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
		matrix_t m;
		qx = t.rx;
		qy = t.ry;
		qz = t.rz;
		qw = t.rw;
		xx = 2 * qx * qx;
		yy = 2 * qy * qy;
		zz = 2 * qz * qz;
		xy = 2 * qx * qy;
		xz = 2 * qx * qz;
		yz = 2 * qy * qz;
		wx = 2 * qw * qx;
		wy = 2 * qw * qy;
		wz = 2 * qw * qz;
		m.m11 = scaled_entry(ONE_Q30_L - (yy + zz), t.sx);
		m.m12 = scaled_entry(xy + wz, t.sx);
		m.m13 = scaled_entry(xz - wy, t.sx);
		m.m21 = scaled_entry(xy - wz, t.sy);
		m.m22 = scaled_entry(ONE_Q30_L - (xx + zz), t.sy);
		m.m23 = scaled_entry(yz + wx, t.sy);
		m.m31 = scaled_entry(xz + wy, t.sz);
		m.m32 = scaled_entry(yz - wx, t.sz);
		m.m33 = scaled_entry(ONE_Q30_L - (xx + yy), t.sz);
		m.tx  = t.tx;
		m.ty  = t.ty;
		m.tz  = t.tz;
		return m;
	endfunction

	function automatic xform_t mk_xform(input int rx, input int ry, input int rz, input int rw,
			input int tx, input int ty, input int tz,
			input int sx, input int sy, input int sz);
		xform_t t;
		t.rx = rx[15:0];
		t.ry = ry[15:0];
		t.rz = rz[15:0];
		t.rw = rw[15:0];
		t.tx = tx;
		t.ty = ty;
		t.tz = tz;
		t.sx = sx[15:0];
		t.sy = sy[15:0];
		t.sz = sz[15:0];
		return t;
	endfunction

	// Pick one of the corner values of a 16-bit signed field
	function automatic logic [15:0] corner16();
		case ($urandom_range(4))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'hffff;
			3: return 16'h0001;
			default: return 16'h0000;
		endcase
	endfunction

	function automatic logic [15:0] ranged16(input int lo, input int hi);
		int v;
		v = lo + int'($urandom_range(hi - lo));
		return v[15:0];
	endfunction

	task automatic check_entry(input string name, input logic signed [31:0] exp_v,
			input logic signed [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d (0x%08h), got %0d (0x%08h)",
				name, exp_v, exp_v, act_v, act_v);
			n_errors++;
		end
	endtask

	// Drive words from the pending queue; predict each one as it is taken
	always @(posedge clk or negedge arst_n) begin : driver
		xform_t nxt;
		int     count;
		bit     taken;
		bit     drain;
		bit     idle;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				expected_matrices.push_back(predict_matrix(cur));
			end
			count = n_accepted + (taken ? 1 : 0);
			n_accepted <= count;
			// hold the word while the block is busy
			if (!(start && busy)) begin
				drain = (count == n_directed || count == DRAIN_MID) && (count != n_checked);
				idle  = !(count >= BURST_LO && count < BURST_HI) &&
					($urandom_range(99) < IDLE_PCT);
				if (pending_xforms.size() != 0 && !drain && !idle) begin
					nxt = pending_xforms.pop_front();
					cur   <= nxt;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Compare each strobed matrix against the oldest prediction
	always @(posedge clk) begin : monitor
		matrix_t want;
		if (arst_n && done) begin
			if (expected_matrices.size() == 0) begin
				$error("result with no transform outstanding: m11=0x%08h", m11);
				n_errors++;
			end else begin
				want = expected_matrices.pop_front();
				check_entry("m11", want.m11, m11);
				check_entry("m12", want.m12, m12);
				check_entry("m13", want.m13, m13);
				check_entry("m21", want.m21, m21);
				check_entry("m22", want.m22, m22);
				check_entry("m23", want.m23, m23);
				check_entry("m31", want.m31, m31);
				check_entry("m32", want.m32, m32);
				check_entry("m33", want.m33, m33);
				check_entry("out_tx", want.tx, out_tx);
				check_entry("out_ty", want.ty, out_ty);
				check_entry("out_tz", want.tz, out_tz);
				n_checked <= n_checked + 1;
			end
		end
	end

	// Build stimulus, release reset, wait for the pipeline to drain
	initial begin : stimulus
		xform_t t;
		int     mode;
		int     waited;
		// identity, zero quaternion, and each component at -1.0
		pending_xforms.push_back(mk_xform(0, 0, 0, 32767, 0, 0, 0, 256, 256, 256));
		pending_xforms.push_back(mk_xform(0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 256, 256, 256));
		pending_xforms.push_back(mk_xform(0, 0, 0, -32768, 32'h80000000, 32'h80000000,
			32'h80000000, 256, 256, 256));
		pending_xforms.push_back(mk_xform(-32768, 0, 0, 0, 1, -1, 0, 256, 256, 256));
		pending_xforms.push_back(mk_xform(0, -32768, 0, 0, 0, 1, -1, 256, 256, 256));
		pending_xforms.push_back(mk_xform(0, 0, -32768, 0, -1, 0, 1, 256, 256, 256));
		// largest magnitudes, non-unit quaternions, scale extremes
		pending_xforms.push_back(mk_xform(-32768, -32768, -32768, -32768, 0, 0, 0,
			32767, 32767, 32767));
		pending_xforms.push_back(mk_xform(-32768, -32768, -32768, -32768, 0, 0, 0,
			-32768, -32768, -32768));
		pending_xforms.push_back(mk_xform(32767, 32767, 32767, 32767, 0, 0, 0,
			-32768, -32768, -32768));
		pending_xforms.push_back(mk_xform(32767, -32768, 32767, -32768, 0, 0, 0,
			32767, -32768, 0));
		pending_xforms.push_back(mk_xform(-1, -1, -1, -1, 0, 0, 0, 32767, 32767, 32767));
		pending_xforms.push_back(mk_xform(1, 1, 1, 1, 0, 0, 0, -32768, -32768, -32768));
		// exact rounding ties, both signs of product
		pending_xforms.push_back(mk_xform(1024, 1024, 0, 0, 0, 0, 0, 1, 1, 1));
		pending_xforms.push_back(mk_xform(1024, -1024, 0, 0, 0, 0, 0, 1, 1, 1));
		pending_xforms.push_back(mk_xform(1024, 1024, 0, 0, 0, 0, 0, -1, -1, -1));
		pending_xforms.push_back(mk_xform(0, 1024, 1024, 1024, 0, 0, 0, 3, -3, 1));
		// quarter turn about z, translation bit patterns
		pending_xforms.push_back(mk_xform(0, 0, 23170, 23170, 32'h7fffffff, -1,
			32'h80000000, 256, 256, 256));
		pending_xforms.push_back(mk_xform(12345, -23456, 3456, -7890, 32'h55555555,
			32'haaaaaaaa, 32'h0000ffff, 0, 0, 0));
		pending_xforms.push_back(mk_xform(-12345, 23456, -3456, 7890, 32'haaaaaaaa,
			32'h55555555, 32'hffff0000, 512, -512, 128));
		n_directed = pending_xforms.size();

		for (int i = 0; i < N_RANDOM; i++) begin
			mode = $urandom_range(9);
			t.tx = $urandom;
			t.ty = $urandom;
			t.tz = $urandom;
			if (mode <= 4) begin
				// anything the fields allow
				t.rx = QUAT_W'($urandom);
				t.ry = QUAT_W'($urandom);
				t.rz = QUAT_W'($urandom);
				t.rw = QUAT_W'($urandom);
				t.sx = SCALE_W'($urandom);
				t.sy = SCALE_W'($urandom);
				t.sz = SCALE_W'($urandom);
			end else if (mode <= 6) begin
				// plausible rotations with modest scale
				t.rx = ranged16(-23170, 23170);
				t.ry = ranged16(-23170, 23170);
				t.rz = ranged16(-23170, 23170);
				t.rw = ranged16(0, 32767);
				t.sx = ranged16(-1024, 1024);
				t.sy = ranged16(-1024, 1024);
				t.sz = ranged16(-1024, 1024);
			end else if (mode == 7) begin
				t.rx = corner16();
				t.ry = corner16();
				t.rz = corner16();
				t.rw = corner16();
				t.sx = corner16();
				t.sy = corner16();
				t.sz = corner16();
			end else begin
				// small values land near rounding boundaries
				t.rx = ranged16(-2048, 2047);
				t.ry = ranged16(-2048, 2047);
				t.rz = ranged16(-2048, 2047);
				t.rw = ranged16(-2048, 2047);
				t.sx = ranged16(-16, 16);
				t.sy = ranged16(-16, 16);
				t.sz = ranged16(-16, 16);
			end
			pending_xforms.push_back(t);
		end
		n_total = pending_xforms.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (n_accepted < n_total) begin
			@(posedge clk);
		end
		waited = 0;
		while (expected_matrices.size() != 0 && waited < 200) begin
			@(posedge clk);
			waited++;
		end
		// catch any stray strobes after the last word
		repeat (8) @(posedge clk);
		if (expected_matrices.size() != 0) begin
			$error("%0d transforms never produced a matrix", expected_matrices.size());
			n_errors += expected_matrices.size();
		end

		$display("Checked %0d matrices from %0d transforms (%0d directed corner cases).",
			n_checked, n_total, n_directed);
		$display("Covered full-range, corner, rounding-tie and back-to-back traffic.");
		if (n_errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Drop the run if the pipeline hangs
	initial begin : watchdog
		#5_000_000;
		$error("timeout: %0d of %0d transforms taken, %0d matrices checked",
			n_accepted, n_total, n_checked);
		$display("Some tests failed");
		$finish;
	end

endmodule

/* quaternion_transform_to_matrix.f */
rtl/core/qtm_pkg.sv
rtl/core/qtm_scale_round.sv
rtl/core/quaternion_transform_to_matrix.sv
rtl/core/qtm_checker.sv
dv/tb_top.sv
